### hdl/bcc_pkg.sv
// Package for the button click classifier: configuration and result types,
// register indexes, action codes and event flag positions.
// No dependencies.
`default_nettype none

package bcc_pkg;

    localparam int CNT_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int EV_W    = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_GAP_TICKS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 2'd3;

    // Reset values of the registers
    localparam logic             ACTIVE_LEVEL_RST     = 1'b0;
    localparam logic [CNT_W-1:0] DEBOUNCE_TICKS_RST   = 16'd20;
    localparam logic [CNT_W-1:0] DOUBLE_GAP_TICKS_RST = 16'd350;
    localparam logic [CNT_W-1:0] LONG_PRESS_TICKS_RST = 16'd1000;

    // Item actions
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Bit positions in the sticky event register
    localparam int EV_SHORT  = 0;
    localparam int EV_DOUBLE = 1;
    localparam int EV_LONG   = 2;

    typedef struct packed {
        logic             active_level;
        logic [CNT_W-1:0] debounce_ticks;
        logic [CNT_W-1:0] double_gap_ticks;
        logic [CNT_W-1:0] long_press_ticks;
    } cfg_t;

    typedef struct packed {
        logic pressed;
        logic short_event;
        logic double_event;
        logic long_event;
    } result_t;

endpackage

`default_nettype wire

### hdl/bcc_if.sv
// Stream interfaces of the button click classifier: input items and results,
// each with valid/ready. No dependencies.
`default_nettype none

interface bcc_in_if;
    logic valid;
    logic ready;
    logic action;
    logic pin_level;

    modport source (output valid, output action, output pin_level, input ready);
    modport sink   (input valid, input action, input pin_level, output ready);
endinterface

interface bcc_out_if;
    logic valid;
    logic ready;
    logic pressed;
    logic short_event;
    logic double_event;
    logic long_event;

    modport source (output valid, output pressed, output short_event,
                    output double_event, output long_event, input ready);
    modport sink   (input valid, input pressed, input short_event,
                    input double_event, input long_event, output ready);
endinterface

`default_nettype wire

### hdl/bcc_cfg_regs.sv
// Configuration register file of the button click classifier.
// Depends on bcc_pkg.
`default_nettype none

module bcc_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [bcc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bcc_pkg::CFG_W-1:0]        cfg_wdata,
    output bcc_pkg::cfg_t                         cfg
);

    bcc_pkg::cfg_t cfg_reg;
    bcc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                bcc_pkg::REG_ACTIVE_LEVEL:     cfg_next.active_level     = cfg_wdata[0];
                bcc_pkg::REG_DEBOUNCE_TICKS:   cfg_next.debounce_ticks   = cfg_wdata;
                bcc_pkg::REG_DOUBLE_GAP_TICKS: cfg_next.double_gap_ticks = cfg_wdata;
                bcc_pkg::REG_LONG_PRESS_TICKS: cfg_next.long_press_ticks = cfg_wdata;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_level     <= bcc_pkg::ACTIVE_LEVEL_RST;
            cfg_reg.debounce_ticks   <= bcc_pkg::DEBOUNCE_TICKS_RST;
            cfg_reg.double_gap_ticks <= bcc_pkg::DOUBLE_GAP_TICKS_RST;
            cfg_reg.long_press_ticks <= bcc_pkg::LONG_PRESS_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### hdl/bcc_classifier.sv
// Debounce and click classification state with its next-state logic.
// Advances one item per enabled cycle. Depends on bcc_pkg.
`default_nettype none

module bcc_classifier (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step_en,
    input  wire logic    action,
    input  wire logic    pin_level,
    input  wire bcc_pkg::cfg_t cfg,
    output bcc_pkg::result_t result
);

    logic                       stable_reg,    stable_next;
    logic [bcc_pkg::CNT_W-1:0]  debounce_reg,  debounce_next;
    logic [bcc_pkg::CNT_W-1:0]  hold_reg,      hold_next;
    logic                       long_done_reg, long_done_next;
    logic                       waiting_reg,   waiting_next;
    logic [bcc_pkg::CNT_W-1:0]  gap_reg,       gap_next;
    logic [bcc_pkg::EV_W-1:0]   events_reg,    events_next;
    logic                       pin_active;

    assign pin_active = (pin_level == cfg.active_level);

    always_comb
    begin
        stable_next    = stable_reg;
        debounce_next  = debounce_reg;
        hold_next      = hold_reg;
        long_done_next = long_done_reg;
        waiting_next   = waiting_reg;
        gap_next       = gap_reg;
        events_next    = events_reg;
        if (step_en)
        begin
            if (action == bcc_pkg::ACT_TICK)
            begin
                // debounce: accept a changed level once it has persisted
                if (pin_active != stable_reg)
                begin
                    if (debounce_next < cfg.debounce_ticks)
                        debounce_next = debounce_next + 16'd1;
                    if (debounce_next >= cfg.debounce_ticks)
                    begin
                        stable_next   = pin_active;
                        debounce_next = '0;
                        if (pin_active)
                        begin
                            hold_next      = '0;
                            long_done_next = 1'b0;
                        end
                        else if (!long_done_reg)
                        begin
                            // release of a click: open the gap or close a double
                            if (!waiting_reg)
                                waiting_next = 1'b1;
                            else
                            begin
                                events_next[bcc_pkg::EV_DOUBLE] = 1'b1;
                                waiting_next = 1'b0;
                            end
                            gap_next = '0;
                        end
                    end
                end
                else
                begin
                    debounce_next = '0;
                end

                if (stable_next)
                begin
                    if (hold_next < cfg.long_press_ticks)
                        hold_next = hold_next + 16'd1;
                    if ((hold_next >= cfg.long_press_ticks) && !long_done_next)
                    begin
                        events_next[bcc_pkg::EV_LONG] = 1'b1;
                        long_done_next = 1'b1;
                        waiting_next   = 1'b0;
                        gap_next       = '0;
                    end
                end
                else if (waiting_next)
                begin
                    if (gap_next < cfg.double_gap_ticks)
                        gap_next = gap_next + 16'd1;
                    else
                    begin
                        events_next[bcc_pkg::EV_SHORT] = 1'b1;
                        waiting_next = 1'b0;
                        gap_next     = '0;
                    end
                end
            end
            else
            begin
                events_next = '0;
            end
        end
    end

    always_comb
    begin
        result.pressed      = stable_next;
        result.short_event  = 1'b0;
        result.double_event = 1'b0;
        result.long_event   = 1'b0;
        if (action == bcc_pkg::ACT_READ)
        begin
            result.short_event  = events_reg[bcc_pkg::EV_SHORT];
            result.double_event = events_reg[bcc_pkg::EV_DOUBLE];
            result.long_event   = events_reg[bcc_pkg::EV_LONG];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg    <= 1'b0;
            debounce_reg  <= '0;
            hold_reg      <= '0;
            long_done_reg <= 1'b0;
            waiting_reg   <= 1'b0;
            gap_reg       <= '0;
            events_reg    <= '0;
        end
        else
        begin
            stable_reg    <= stable_next;
            debounce_reg  <= debounce_next;
            hold_reg      <= hold_next;
            long_done_reg <= long_done_next;
            waiting_reg   <= waiting_next;
            gap_reg       <= gap_next;
            events_reg    <= events_next;
        end
    end

    // a long press that is still held never leaves a click waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (long_done_reg && stable_reg) |-> !waiting_reg)
        else $error("click waiting during a held long press");

    // a read clears every sticky event
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && action == bcc_pkg::ACT_READ) |=> (events_reg == '0))
        else $error("events not cleared by read");

    // without a step the state holds
    assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> ($stable(stable_reg) && $stable(hold_reg) && $stable(gap_reg)
                      && $stable(debounce_reg) && $stable(events_reg)))
        else $error("state moved without a step");

endmodule

`default_nettype wire

### hdl/button_click_classifier.sv
// Button click classifier: debounced push button with short, double and long press events.
// Each item passes the input register, then the result register, before its result is offered.
// One item per cycle while out_ch is ready; a new item is taken while a finished result waits.
// Reset: rst_n clears the state, the sticky events and both stages, and loads register defaults.
// Depends on bcc_pkg, bcc_if, bcc_cfg_regs and bcc_classifier.
`default_nettype none

module button_click_classifier (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    bcc_in_if.sink                             in_ch,
    bcc_out_if.source                          out_ch,
    input  wire logic                          cfg_we,
    input  wire logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bcc_pkg::CFG_W-1:0]     cfg_wdata
);

    bcc_pkg::cfg_t    cfg;
    bcc_pkg::result_t step_result;
    bcc_pkg::result_t result_reg;

    logic in_valid_reg;
    logic in_action_reg;
    logic in_pin_reg;
    logic out_valid_reg;
    logic proc_en;
    logic in_take;

    // advance the input stage when the result register is free or draining
    assign proc_en      = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || proc_en;
    assign in_take      = in_ch.valid && in_ch.ready;

    bcc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bcc_classifier u_classifier (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (proc_en),
        .action    (in_action_reg),
        .pin_level (in_pin_reg),
        .cfg       (cfg),
        .result    (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                in_valid_reg <= in_ch.valid;
            if (proc_en)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_action_reg <= in_ch.action;
            in_pin_reg    <= in_ch.pin_level;
        end
        if (proc_en)
            result_reg <= step_result;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.pressed      = result_reg.pressed;
    assign out_ch.short_event  = result_reg.short_event;
    assign out_ch.double_event = result_reg.double_event;
    assign out_ch.long_event   = result_reg.long_event;

    // a stalled input stage keeps its item
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !proc_en) |=> in_valid_reg)
        else $error("input stage dropped an item");

    // a processed item always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        proc_en |=> out_valid_reg)
        else $error("processed item lost");

    // input back-pressure only when both stages are full
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (in_valid_reg && out_valid_reg && !out_ch.ready))
        else $error("needless input stall");

endmodule

`default_nettype wire

### tb/sv/button_click_classifier_test.sv
// Self-checking bench for button_click_classifier: debounce, short/double/long
// classification and read-and-clear of the sticky events, under random stalls.
// Depends on bcc_pkg, bcc_if and the button_click_classifier RTL.

module button_click_classifier_test;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bcc_pkg::CFG_W-1:0]     cfg_wdata;

    bcc_in_if  in_ch();
    bcc_out_if out_ch();

    button_click_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow of the block: configuration and classifier state
    bcc_pkg::cfg_t             button_cfg;
    logic                      stable_lvl;
    logic [bcc_pkg::CNT_W-1:0] deb_cnt;
    logic [bcc_pkg::CNT_W-1:0] hold_cnt;
    logic [bcc_pkg::CNT_W-1:0] gap_cnt;
    logic                      long_seen;
    logic                      click_pending;
    logic [bcc_pkg::EV_W-1:0]  ev_flags;

    bcc_pkg::result_t expected_results[$];
    int unsigned      n_sent;
    int unsigned      n_checked;
    int unsigned      n_errors;
    bit               src_gaps;
    bit               sink_gaps;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic bcc_pkg::result_t classify_item(logic act, logic pin);
        bcc_pkg::result_t r;
        logic             raw;
        r = '0;
        if (act == bcc_pkg::ACT_TICK)
        begin
            raw = (pin == button_cfg.active_level);
            if (raw != stable_lvl)
            begin
                if (deb_cnt < button_cfg.debounce_ticks)
                    deb_cnt++;
                if (deb_cnt >= button_cfg.debounce_ticks)
                begin
                    stable_lvl = raw;
                    deb_cnt = '0;
                    if (stable_lvl)
                    begin
                        hold_cnt = '0;
                        long_seen = 1'b0;
                    end
                    else if (!long_seen)
                    begin
                        // second release inside the gap makes a double
                        if (!click_pending)
                            click_pending = 1'b1;
                        else
                        begin
                            ev_flags[bcc_pkg::EV_DOUBLE] = 1'b1;
                            click_pending = 1'b0;
                        end
                        gap_cnt = '0;
                    end
                end
            end
            else
                deb_cnt = '0;

            if (stable_lvl)
            begin
                if (hold_cnt < button_cfg.long_press_ticks)
                    hold_cnt++;
                if (hold_cnt >= button_cfg.long_press_ticks && !long_seen)
                begin
                    ev_flags[bcc_pkg::EV_LONG] = 1'b1;
                    long_seen = 1'b1;
                    click_pending = 1'b0;
                    gap_cnt = '0;
                end
            end
            else if (click_pending)
            begin
                if (gap_cnt < button_cfg.double_gap_ticks)
                    gap_cnt++;
                else
                begin
                    ev_flags[bcc_pkg::EV_SHORT] = 1'b1;
                    click_pending = 1'b0;
                    gap_cnt = '0;
                end
            end
        end
        else
        begin
            r.short_event  = ev_flags[bcc_pkg::EV_SHORT];
            r.double_event = ev_flags[bcc_pkg::EV_DOUBLE];
            r.long_event   = ev_flags[bcc_pkg::EV_LONG];
            ev_flags = '0;
        end
        r.pressed = stable_lvl;
        return r;
    endfunction

    task automatic report_error(string msg);
        n_errors++;
        if (n_errors <= 20)
            $display("ERROR at %0t: %0s", $realtime, msg);
    endtask

    task automatic check_result();
        bcc_pkg::result_t want;
        if (expected_results.size() == 0)
        begin
            report_error("result transfer with no item outstanding");
            return;
        end
        want = expected_results.pop_front();
        if (out_ch.pressed !== want.pressed)
            report_error($sformatf("result %0d pressed: got %b, expected %b",
                                   n_checked, out_ch.pressed, want.pressed));
        if (out_ch.short_event !== want.short_event)
            report_error($sformatf("result %0d short_event: got %b, expected %b",
                                   n_checked, out_ch.short_event, want.short_event));
        if (out_ch.double_event !== want.double_event)
            report_error($sformatf("result %0d double_event: got %b, expected %b",
                                   n_checked, out_ch.double_event, want.double_event));
        if (out_ch.long_event !== want.long_event)
            report_error($sformatf("result %0d long_event: got %b, expected %b",
                                   n_checked, out_ch.long_event, want.long_event));
        n_checked++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            check_result();
        out_ch.ready <= !sink_gaps || ($urandom_range(0, 99) >= 15);
    end

    task automatic send_item(logic act, logic pin);
        while (src_gaps && $urandom_range(0, 99) < 15)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.pin_level <= pin;
        do
            @(posedge clk);
        while (!in_ch.ready);
        // transfer taken at this edge
        expected_results.push_back(classify_item(act, pin));
        n_sent++;
    endtask

    // Hold the input quiet until every result is back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [bcc_pkg::CFG_IDX_W-1:0] idx,
                             logic [bcc_pkg::CFG_W-1:0] data);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            bcc_pkg::REG_ACTIVE_LEVEL:     button_cfg.active_level     = data[0];
            bcc_pkg::REG_DEBOUNCE_TICKS:   button_cfg.debounce_ticks   = data;
            bcc_pkg::REG_DOUBLE_GAP_TICKS: button_cfg.double_gap_ticks = data;
            bcc_pkg::REG_LONG_PRESS_TICKS: button_cfg.long_press_ticks = data;
            default: ;
        endcase
    endtask

    task automatic write_all(logic lvl, int unsigned deb, int unsigned gap, int unsigned hold);
        write_reg(bcc_pkg::REG_ACTIVE_LEVEL, {{(bcc_pkg::CFG_W-1){1'b0}}, lvl});
        write_reg(bcc_pkg::REG_DEBOUNCE_TICKS, deb[bcc_pkg::CFG_W-1:0]);
        write_reg(bcc_pkg::REG_DOUBLE_GAP_TICKS, gap[bcc_pkg::CFG_W-1:0]);
        write_reg(bcc_pkg::REG_LONG_PRESS_TICKS, hold[bcc_pkg::CFG_W-1:0]);
    endtask

    // Drive n ticks at one button state, with bounce and stray reads mixed in
    task automatic hold_level(logic want_pressed, int unsigned n);
        logic pin;
        repeat (n)
        begin
            if ($urandom_range(0, 99) < 8)
                send_item(bcc_pkg::ACT_READ, 1'($urandom_range(0, 1)));
            pin = want_pressed ? button_cfg.active_level : ~button_cfg.active_level;
            if ($urandom_range(0, 99) < 5)
                pin = ~pin;
            send_item(bcc_pkg::ACT_TICK, pin);
        end
    endtask

    task automatic press_release();
        int unsigned deb;
        int unsigned gap;
        int unsigned hold;
        deb  = 32'(button_cfg.debounce_ticks);
        gap  = 32'(button_cfg.double_gap_ticks);
        hold = 32'(button_cfg.long_press_ticks);
        if ($urandom_range(0, 9) == 0)
        begin
            // plain noise
            repeat ($urandom_range(3, 12))
                send_item($urandom_range(0, 99) < 10, 1'($urandom_range(0, 1)));
            return;
        end
        if ($urandom_range(0, 3) == 0)
            hold_level(1'b1, $urandom_range(deb + hold, deb + hold + 4));
        else
            hold_level(1'b1, $urandom_range(1, deb + (hold > 1 ? hold - 1 : 1)));
        hold_level(1'b0, $urandom_range(1, deb + gap + 4));
        if ($urandom_range(0, 29) == 0)
            wait_drained();
    endtask

    task automatic test_defaults();
        send_item(bcc_pkg::ACT_READ, 1'b1);
        send_item(bcc_pkg::ACT_READ, 1'b0);
        repeat (4) send_item(bcc_pkg::ACT_TICK, 1'b0);
        send_item(bcc_pkg::ACT_TICK, 1'b1);
        send_item(bcc_pkg::ACT_READ, 1'b0);
    endtask

    task automatic test_click_kinds();
        write_all(1'b1, 1, 2, 4);
        // single click, then let the gap run out
        send_item(bcc_pkg::ACT_TICK, 1'b1);
        repeat (4) send_item(bcc_pkg::ACT_TICK, 1'b0);
        send_item(bcc_pkg::ACT_READ, 1'b1);
        // double click
        send_item(bcc_pkg::ACT_TICK, 1'b1);
        send_item(bcc_pkg::ACT_TICK, 1'b0);
        send_item(bcc_pkg::ACT_TICK, 1'b1);
        send_item(bcc_pkg::ACT_TICK, 1'b0);
        send_item(bcc_pkg::ACT_READ, 1'b0);
        // long press, its release makes no click
        repeat (5) send_item(bcc_pkg::ACT_TICK, 1'b1);
        repeat (4) send_item(bcc_pkg::ACT_TICK, 1'b0);
        send_item(bcc_pkg::ACT_READ, 1'b1);
    endtask

    task automatic test_lowered_thresholds();
        write_all(1'b1, 1, 1000, 1000);
        repeat (10) send_item(bcc_pkg::ACT_TICK, 1'b1);
        write_reg(bcc_pkg::REG_LONG_PRESS_TICKS, 16'd5);
        send_item(bcc_pkg::ACT_TICK, 1'b1);
        write_reg(bcc_pkg::REG_DEBOUNCE_TICKS, 16'd10);
        repeat (5) send_item(bcc_pkg::ACT_TICK, 1'b0);
        write_reg(bcc_pkg::REG_DEBOUNCE_TICKS, 16'd2);
        send_item(bcc_pkg::ACT_TICK, 1'b0);
        send_item(bcc_pkg::ACT_READ, 1'b0);
        write_reg(bcc_pkg::REG_DEBOUNCE_TICKS, 16'd1);
        send_item(bcc_pkg::ACT_TICK, 1'b1);
        repeat (6) send_item(bcc_pkg::ACT_TICK, 1'b0);
        write_reg(bcc_pkg::REG_DOUBLE_GAP_TICKS, 16'd3);
        send_item(bcc_pkg::ACT_TICK, 1'b0);
        send_item(bcc_pkg::ACT_READ, 1'b1);
    endtask

    task automatic test_max_thresholds();
        write_all(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (6) hold_level(1'($urandom_range(0, 1)), $urandom_range(10, 40));
        send_item(bcc_pkg::ACT_READ, 1'b0);
    endtask

    task automatic test_min_thresholds();
        int unsigned stop_at;
        write_all(1'b1, 1, 1, 1);
        stop_at = n_sent + 80;
        while (n_sent < stop_at)
            press_release();
    endtask

    task automatic test_random_gestures(int unsigned n_phases, int unsigned per_phase);
        int unsigned stop_at;
        repeat (n_phases)
        begin
            write_all(1'($urandom_range(0, 1)), $urandom_range(1, 4), $urandom_range(1, 10),
                      $urandom_range(1, 25));
            stop_at = n_sent + per_phase;
            while (n_sent < stop_at)
                press_release();
            send_item(bcc_pkg::ACT_READ, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_back_to_back();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        test_random_gestures(1, 300);
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.action    = bcc_pkg::ACT_TICK;
        in_ch.pin_level = 1'b0;
        src_gaps        = 1'b1;
        sink_gaps       = 1'b1;
        n_sent          = 0;
        n_checked       = 0;
        n_errors        = 0;

        button_cfg.active_level     = bcc_pkg::ACTIVE_LEVEL_RST;
        button_cfg.debounce_ticks   = bcc_pkg::DEBOUNCE_TICKS_RST;
        button_cfg.double_gap_ticks = bcc_pkg::DOUBLE_GAP_TICKS_RST;
        button_cfg.long_press_ticks = bcc_pkg::LONG_PRESS_TICKS_RST;
        stable_lvl    = 1'b0;
        deb_cnt       = '0;
        hold_cnt      = '0;
        gap_cnt       = '0;
        long_seen     = 1'b0;
        click_pending = 1'b0;
        ev_flags      = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_click_kinds();
        test_lowered_thresholds();
        test_max_thresholds();
        test_min_thresholds();
        test_random_gestures(5, 230);
        test_back_to_back();

        wait_drained();
        repeat (8) @(posedge clk);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
